FILE: sv/lsbr_pkg.sv
// shared types and constants for the lcd screen buffer refresher
`timescale 1ns / 1ps

package lsbr_pkg;

	localparam int SCREEN_W = 2;
	localparam int POS_W = 4;
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 7;
	localparam int NIB_W = 4;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SELECT = 2'd1;
	localparam logic [1:0] CMD_SERVICE = 2'd2;
	localparam logic [1:0] CMD_CHECKSUM = 2'd3;

	localparam logic KIND_NIBBLE = 1'b0;
	localparam logic KIND_CHECKSUM = 1'b1;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
	localparam logic [7:0] LCD_ADDR_HI_MASK = 8'h70;
	localparam logic [7:0] LCD_ADDR_LO_MASK = 8'h0f;
	localparam logic [ADDR_W-1:0] LCD_FIRST_ADDR = 7'h00;
	localparam logic [ADDR_W-1:0] HALF_ADDR_RESET = 7'h40;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_BLANK = 8'h00;

	typedef struct packed {
		logic [1:0] command;
		logic [SCREEN_W-1:0] screen;
		logic [POS_W-1:0] position;
		logic [CHAR_W-1:0] character;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic register_select;
		logic [NIB_W-1:0] nibble;
		logic [7:0] checksum;
		logic last;
	} out_item_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_ADDR_HI,
		EM_ADDR_LO,
		EM_CHAR_HI,
		EM_CHAR_LO,
		EM_SUM
	} emit_t;

	typedef struct packed {
		logic accept;
		logic init_wr;
		logic idx_clr;
		logic idx_inc;
		logic rd_first;
		logic rd_next;
		logic rd_sum;
		logic acc_clr;
		logic mark_shown;
		emit_t emit;
		logic addr_sel;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic refresh_needed;
		logic idx_last;
		logic half_next;
	} dp_sts_t;

	// power-up contents of screen 0
	function automatic logic [7:0] init_char(input int unsigned idx, input int unsigned len);
		logic [7:0] c;
		if (idx >= len) begin
			c = CHAR_BLANK;
		end else begin
			case (idx)
				0: c = 8'h53;
				1: c = 8'h70;
				2: c = 8'h61;
				3: c = 8'h6d;
				default: c = CHAR_SPACE;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: sv/lsbr_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lsbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/lsbr_dp.sv
// datapath: screen memory, display state, sequencing counters and result register
`timescale 1ns / 1ps

module lsbr_dp #(
	parameter int BUFFER_LEN = 16,
	parameter int SCREEN_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input lsbr_pkg::dp_cmd_t cmd,
	output lsbr_pkg::dp_sts_t sts,
	input lsbr_pkg::in_item_t item,
	input logic cfg_wen,
	input logic [lsbr_pkg::ADDR_W-1:0] cfg_wdata,
	output lsbr_pkg::out_item_t result,
	output logic strobe
);

	localparam int DEPTH = SCREEN_COUNT * BUFFER_LEN;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(BUFFER_LEN);
	localparam int HALF = BUFFER_LEN / 2;

	logic [AW-1:0] init_cnt_q;
	logic [IW-1:0] idx_q;
	logic [lsbr_pkg::SCREEN_W-1:0] scr_q;
	logic [lsbr_pkg::SCREEN_W-1:0] shown_q;
	logic [lsbr_pkg::SCREEN_W-1:0] wanted_q;
	logic redraw_q;
	logic [lsbr_pkg::ADDR_W-1:0] half_addr_q;
	logic [7:0] acc_q;
	logic rd_sum_s1;
	logic strobe_q;
	lsbr_pkg::out_item_t result_q;

	logic scr_ok;
	logic pos_ok;
	logic wr_item;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic [IW:0] rd_ofs;
	logic [lsbr_pkg::SCREEN_W-1:0] rd_scr;
	logic [lsbr_pkg::ADDR_W-1:0] lcd_addr;
	logic [7:0] addr_hi;
	logic [7:0] addr_lo;
	lsbr_pkg::out_item_t next_res;

	assign scr_ok = int'(item.screen) < SCREEN_COUNT;
	assign pos_ok = int'(item.position) < BUFFER_LEN;
	assign wr_item = cmd.accept && (item.command == lsbr_pkg::CMD_WRITE) && scr_ok && pos_ok;

	assign ram_we = cmd.init_wr | wr_item;
	assign ram_waddr = cmd.init_wr ? init_cnt_q
		: AW'(int'(item.screen) * BUFFER_LEN + int'(item.position));
	assign ram_wdata = cmd.init_wr ? lsbr_pkg::init_char(int'(init_cnt_q), BUFFER_LEN)
		: item.character;

	assign ram_re = cmd.rd_first | cmd.rd_next | cmd.rd_sum;
	assign rd_ofs = cmd.rd_first ? '0 : (cmd.rd_sum ? {1'b0, idx_q} : {1'b0, idx_q} + 1'b1);
	assign rd_scr = cmd.rd_sum ? scr_q : wanted_q;
	assign ram_raddr = AW'(int'(rd_scr) * BUFFER_LEN + int'(rd_ofs));

	lsbr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.init_last = init_cnt_q == AW'(DEPTH - 1);
	assign sts.refresh_needed = (shown_q != wanted_q) | redraw_q;
	assign sts.idx_last = idx_q == IW'(BUFFER_LEN - 1);
	assign sts.half_next = (int'(idx_q) + 1) == HALF;

	assign lcd_addr = cmd.addr_sel ? half_addr_q : lsbr_pkg::LCD_FIRST_ADDR;
	assign addr_hi = ({1'b0, lcd_addr} & lsbr_pkg::LCD_ADDR_HI_MASK) | lsbr_pkg::LCD_SET_DDRAM;
	assign addr_lo = {1'b0, lcd_addr} & lsbr_pkg::LCD_ADDR_LO_MASK;

	always_comb begin
		next_res = '0;
		next_res.last = cmd.last;
		case (cmd.emit)
			lsbr_pkg::EM_ADDR_HI: begin
				next_res.kind = lsbr_pkg::KIND_NIBBLE;
				next_res.register_select = lsbr_pkg::RS_COMMAND;
				next_res.nibble = addr_hi[7:4];
			end
			lsbr_pkg::EM_ADDR_LO: begin
				next_res.kind = lsbr_pkg::KIND_NIBBLE;
				next_res.register_select = lsbr_pkg::RS_COMMAND;
				next_res.nibble = addr_lo[3:0];
			end
			lsbr_pkg::EM_CHAR_HI: begin
				next_res.kind = lsbr_pkg::KIND_NIBBLE;
				next_res.register_select = lsbr_pkg::RS_DATA;
				next_res.nibble = ram_rdata[7:4];
			end
			lsbr_pkg::EM_CHAR_LO: begin
				next_res.kind = lsbr_pkg::KIND_NIBBLE;
				next_res.register_select = lsbr_pkg::RS_DATA;
				next_res.nibble = ram_rdata[3:0];
			end
			lsbr_pkg::EM_SUM: begin
				next_res.kind = lsbr_pkg::KIND_CHECKSUM;
				next_res.checksum = (int'(scr_q) < SCREEN_COUNT) ? acc_q : 8'h00;
			end
			default: begin
				next_res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
			idx_q <= '0;
			shown_q <= '0;
			wanted_q <= '0;
			redraw_q <= 1'b1;
			half_addr_q <= lsbr_pkg::HALF_ADDR_RESET;
			rd_sum_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cfg_wen) begin
				half_addr_q <= cfg_wdata;
			end
			if (cmd.accept && (item.command == lsbr_pkg::CMD_SELECT) && scr_ok) begin
				wanted_q <= item.screen;
			end
			if (cmd.mark_shown) begin
				shown_q <= wanted_q;
				redraw_q <= 1'b0;
			end else if (wr_item && (item.screen == shown_q)) begin
				redraw_q <= 1'b1;
			end
			rd_sum_s1 <= cmd.rd_sum;
			strobe_q <= cmd.emit != lsbr_pkg::EM_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			scr_q <= item.screen;
		end
		if (cmd.acc_clr) begin
			acc_q <= 8'h00;
		end else if (rd_sum_s1) begin
			acc_q <= acc_q + ram_rdata;
		end
		result_q <= next_res;
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

FILE: sv/lsbr_ctrl.sv
// controller: memory fill after reset, command decode, refresh and checksum sequencing
`timescale 1ns / 1ps

module lsbr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] command,
	input lsbr_pkg::dp_sts_t sts,
	output lsbr_pkg::dp_cmd_t cmd,
	output logic busy
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_A0H,
		S_A0L,
		S_CH,
		S_CL,
		S_A1H,
		S_A1L,
		S_SUM,
		S_SUMW,
		S_SUMO
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.emit = lsbr_pkg::EM_NONE;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					if (command == lsbr_pkg::CMD_SERVICE && sts.refresh_needed) begin
						state_d = S_A0H;
					end else if (command == lsbr_pkg::CMD_CHECKSUM) begin
						state_d = S_SUM;
					end
				end
			end
			S_A0H: begin
				cmd.emit = lsbr_pkg::EM_ADDR_HI;
				state_d = S_A0L;
			end
			S_A0L: begin
				cmd.emit = lsbr_pkg::EM_ADDR_LO;
				cmd.rd_first = 1'b1;
				state_d = S_CH;
			end
			S_CH: begin
				cmd.emit = lsbr_pkg::EM_CHAR_HI;
				state_d = S_CL;
			end
			S_CL: begin
				cmd.emit = lsbr_pkg::EM_CHAR_LO;
				if (sts.idx_last) begin
					cmd.last = 1'b1;
					cmd.mark_shown = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d = sts.half_next ? S_A1H : S_CH;
				end
			end
			S_A1H: begin
				cmd.emit = lsbr_pkg::EM_ADDR_HI;
				cmd.addr_sel = 1'b1;
				state_d = S_A1L;
			end
			S_A1L: begin
				cmd.emit = lsbr_pkg::EM_ADDR_LO;
				cmd.addr_sel = 1'b1;
				state_d = S_CH;
			end
			S_SUM: begin
				cmd.rd_sum = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SUMW;
				end
			end
			S_SUMW: begin
				state_d = S_SUMO;
			end
			S_SUMO: begin
				cmd.emit = lsbr_pkg::EM_SUM;
				cmd.last = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/lcd_screen_buffer_refresher.sv
// top level of the lcd screen buffer refresher
//
//  port group                 dir  handshake
//  start, busy, item          in   item taken when start is high and busy is low
//  strobe, result             out  one result per strobe, no back pressure
//  cfg_wen, cfg_wdata         in   second-half ddram address, written when cfg_wen is high
//
// write, select and a service with nothing to redraw finish in the accept cycle.
// a refresh emits its 2 * BUFFER_LEN + 4 nibbles one per cycle, the first one
// from the A0H state through the result register. a checksum reads one character
// per cycle and answers after the last; one screen ram read per cycle sets this.
// after reset busy stays high while every screen ram location is loaded with its
// power-up contents.
`timescale 1ns / 1ps

module lcd_screen_buffer_refresher #(
	parameter int BUFFER_LEN = 16,
	parameter int SCREEN_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lsbr_pkg::in_item_t item,
	output logic strobe,
	output lsbr_pkg::out_item_t result,
	input logic cfg_wen,
	input logic [lsbr_pkg::ADDR_W-1:0] cfg_wdata
);

	lsbr_pkg::dp_cmd_t cmd;
	lsbr_pkg::dp_sts_t sts;

	lsbr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(item.command),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	lsbr_dp #(
		.BUFFER_LEN(BUFFER_LEN),
		.SCREEN_COUNT(SCREEN_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.item(item),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.result(result),
		.strobe(strobe)
	);

endmodule

FILE: test/lcd_screen_buffer_refresher_tb.sv
// testbench for the lcd screen buffer refresher: directed and random items checked by a predictor
`timescale 1ns / 1ps

module lcd_screen_buffer_refresher_tb;

	localparam int BUF_LEN = 16;
	localparam int SCR_CNT = 4;
	localparam int SETTLE = 80;
	localparam int STALL_LIMIT = 3000;
	localparam int RAND_PER_SET = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lsbr_pkg::in_item_t item = '0;
	logic strobe;
	lsbr_pkg::out_item_t result;
	logic cfg_wen = 1'b0;
	logic [lsbr_pkg::ADDR_W-1:0] cfg_wdata = '0;

	// predicted block state
	logic [7:0] char_mem [SCR_CNT*BUF_LEN];
	logic [1:0] shown_scr;
	logic [1:0] wanted_scr;
	logic redraw;
	logic [lsbr_pkg::ADDR_W-1:0] half_addr;

	lsbr_pkg::in_item_t pend_q [$];
	lsbr_pkg::out_item_t lcd_out_q [$];

	logic [1:0] gen_wanted;
	int send_idle_pct = 10;
	int fails = 0;
	int items_sent = 0;
	int results_seen = 0;
	int refreshes = 0;
	int sums = 0;
	int cfg_writes = 0;
	int stall_cnt = 0;

	lcd_screen_buffer_refresher #(
		.BUFFER_LEN(BUF_LEN),
		.SCREEN_COUNT(SCR_CNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function void push_lcd(logic kind, logic rs, logic [3:0] nib, logic [7:0] sum, logic fin);
		lsbr_pkg::out_item_t r;
		r.kind = kind;
		r.register_select = rs;
		r.nibble = nib;
		r.checksum = sum;
		r.last = fin;
		lcd_out_q.push_back(r);
	endfunction

	function void push_ddram_addr(logic [lsbr_pkg::ADDR_W-1:0] a);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = (({1'b0, a} & lsbr_pkg::LCD_ADDR_HI_MASK) | lsbr_pkg::LCD_SET_DDRAM) >> 4;
		lo = {1'b0, a} & lsbr_pkg::LCD_ADDR_LO_MASK;
		push_lcd(lsbr_pkg::KIND_NIBBLE, lsbr_pkg::RS_COMMAND, hi[3:0], 8'h00, 1'b0);
		push_lcd(lsbr_pkg::KIND_NIBBLE, lsbr_pkg::RS_COMMAND, lo[3:0], 8'h00, 1'b0);
	endfunction

	function void predict_lcd(lsbr_pkg::in_item_t it);
		logic [7:0] sum;
		logic [7:0] c;
		int i;
		sum = 8'h00;
		case (it.command)
			lsbr_pkg::CMD_WRITE: begin
				if (it.screen < SCR_CNT && it.position < BUF_LEN) begin
					char_mem[it.screen*BUF_LEN + it.position] = it.character;
					if (it.screen == shown_scr)
						redraw = 1'b1;
				end
			end
			lsbr_pkg::CMD_SELECT: begin
				if (it.screen < SCR_CNT)
					wanted_scr = it.screen;
			end
			lsbr_pkg::CMD_SERVICE: begin
				if (shown_scr != wanted_scr || redraw) begin
					push_ddram_addr(lsbr_pkg::LCD_FIRST_ADDR);
					for (i = 0; i < BUF_LEN; i++) begin
						if (i == BUF_LEN / 2)
							push_ddram_addr(half_addr);
						c = char_mem[wanted_scr*BUF_LEN + i];
						push_lcd(lsbr_pkg::KIND_NIBBLE, lsbr_pkg::RS_DATA, c[7:4], 8'h00,
							1'b0);
						push_lcd(lsbr_pkg::KIND_NIBBLE, lsbr_pkg::RS_DATA, c[3:0], 8'h00,
							i == BUF_LEN - 1);
					end
					shown_scr = wanted_scr;
					redraw = 1'b0;
					refreshes++;
				end
			end
			default: begin
				if (it.screen < SCR_CNT)
					for (i = 0; i < BUF_LEN; i++)
						sum = sum + char_mem[it.screen*BUF_LEN + i];
				push_lcd(lsbr_pkg::KIND_CHECKSUM, lsbr_pkg::RS_COMMAND, 4'h0, sum, 1'b1);
				sums++;
			end
		endcase
	endfunction

	function void add_item(logic [1:0] cmd, logic [1:0] scr, logic [3:0] pos, logic [7:0] ch);
		lsbr_pkg::in_item_t it;
		it.command = cmd;
		it.screen = scr;
		it.position = pos;
		it.character = ch;
		pend_q.push_back(it);
	endfunction

	// random mix of writes (half of them to the wanted screen), selects, services and checksums, with noise
	function void add_random_item();
		logic [1:0] cmd;
		logic [1:0] scr;
		logic [7:0] ch;
		int r;
		r = int'($urandom_range(99));
		scr = 2'($urandom_range(SCR_CNT - 1));
		ch = 8'($urandom_range(255));
		if (r < 50) begin
			cmd = lsbr_pkg::CMD_WRITE;
			if ($urandom_range(1))
				scr = gen_wanted;
		end else if (r < 62) begin
			cmd = lsbr_pkg::CMD_SELECT;
			gen_wanted = scr;
		end else if (r < 85) begin
			cmd = lsbr_pkg::CMD_SERVICE;
		end else begin
			cmd = lsbr_pkg::CMD_CHECKSUM;
		end
		if ($urandom_range(9) == 0)
			ch = $urandom_range(1) ? 8'hff : 8'h00;
		add_item(cmd, scr, 4'($urandom_range(BUF_LEN - 1)), ch);
	endfunction

	task automatic drain();
		while (pend_q.size() != 0)
			@(posedge clk);
		while (lcd_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_half_addr(logic [lsbr_pkg::ADDR_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		half_addr = v;
		cfg_writes++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_lcd(pend_q[0]);
				pend_q.pop_front();
				items_sent++;
			end
			if (start && busy) begin
				// hold the item until taken
			end else if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				item <= pend_q[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lsbr_pkg::out_item_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (lcd_out_q.size() == 0) begin
				$error("unexpected result: kind %0d nibble %h checksum %h",
					result.kind, result.nibble, result.checksum);
				fails++;
			end else begin
				want = lcd_out_q.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					fails++;
				end
				if (result.register_select !== want.register_select) begin
					$error("register_select: expected %0d, got %0d",
						want.register_select, result.register_select);
					fails++;
				end
				if (result.nibble !== want.nibble) begin
					$error("nibble: expected %h, got %h", want.nibble, result.nibble);
					fails++;
				end
				if (result.checksum !== want.checksum) begin
					$error("checksum: expected %h, got %h", want.checksum, result.checksum);
					fails++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] greet;
		logic [lsbr_pkg::ADDR_W-1:0] half_vals [9];
		int i;
		int p;
		int s;
		greet = "Spam";
		for (i = 0; i < SCR_CNT*BUF_LEN; i++)
			char_mem[i] = 8'h00;
		for (i = 0; i < BUF_LEN; i++)
			char_mem[i] = (i < 4) ? greet[31 - 8*i -: 8] : lsbr_pkg::CHAR_SPACE;
		shown_scr = '0;
		wanted_scr = '0;
		redraw = 1'b1;
		half_addr = lsbr_pkg::HALF_ADDR_RESET;
		gen_wanted = '0;
		half_vals = '{7'h00, 7'h7f, 7'h00, 7'h40, 7'h00, 7'h00, 7'h7f, 7'h00, 7'h00};
		half_vals[2] = 7'($urandom_range(127));
		half_vals[4] = 7'($urandom_range(127));
		half_vals[7] = 7'($urandom_range(127));
		half_vals[8] = 7'($urandom_range(127));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		write_half_addr(7'h7f);

		// directed items
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd2, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd1, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_WRITE, 2'd0, 4'd0, 8'hff);
		add_item(lsbr_pkg::CMD_WRITE, 2'd0, 4'd15, 8'h00);
		add_item(lsbr_pkg::CMD_WRITE, 2'd0, 4'd7, 8'h80);
		add_item(lsbr_pkg::CMD_WRITE, 2'd0, 4'd8, 8'h7f);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd3, 4'd15, 8'hff);
		add_item(lsbr_pkg::CMD_WRITE, 2'd2, 4'd3, 8'h5a);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SELECT, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SELECT, 2'd3, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd3, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_WRITE, 2'd3, 4'd15, 8'hff);
		add_item(lsbr_pkg::CMD_WRITE, 2'd3, 4'd14, 8'hff);
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd3, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_SELECT, 2'd2, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_WRITE, 2'd3, 4'd0, 8'h41);
		add_item(lsbr_pkg::CMD_SERVICE, 2'd0, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_WRITE, 2'd1, 4'd9, 8'haa);
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd1, 4'd0, 8'h00);
		add_item(lsbr_pkg::CMD_CHECKSUM, 2'd0, 4'd0, 8'h00);
		gen_wanted = 2'd2;
		drain();

		// random items: sender idles 10, then 78, then never
		for (p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 10 : (p == 1) ? 78 : 0;
			for (s = 0; s < 3; s++) begin
				write_half_addr(half_vals[p*3 + s]);
				for (i = 0; i < RAND_PER_SET; i++)
					add_random_item();
				drain();
			end
		end

		$display("%0d items sent, %0d results checked (%0d refreshes, %0d checksum replies)",
			items_sent, results_seen, refreshes, sums);
		$display("second-half address written %0d times, 0 and 127 included", cfg_writes);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
sv/lsbr_pkg.sv
sv/lsbr_ram.sv
sv/lsbr_dp.sv
sv/lsbr_ctrl.sv
sv/lcd_screen_buffer_refresher.sv
test/lcd_screen_buffer_refresher_tb.sv
